FILE: design/sbv_pkg.sv
package sbv_pkg;

  typedef struct packed {
    logic [15:0] bin_magnitude;
    logic        last_bin;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_bin;
    logic [15:0] out_magnitude;
    logic        has_value;
    logic        frame_done;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_NUM_BANDS    = 3'd0,
    REG_FIRST_BAND   = 3'd1,
    REG_BAND_FACTOR  = 3'd2,
    REG_GAIN_FACTOR  = 3'd3,
    REG_FREQ_SHIFT   = 3'd4,
    REG_FIRST_OSC    = 3'd5,
    REG_GAINS        = 3'd6
  } reg_index_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_SQRT, S_GMUL, S_VAL, S_BUPD, S_GCHK, S_GUPD, S_SUM, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    MUL_GAIN, MUL_BAND, MUL_GLIM
  } mul_sel_e;

  typedef struct packed {
    logic     accept;
    logic     sqrt_start;
    logic     sqrt_step;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     val_capture;
    logic     band_upd;
    logic     gain_upd;
    logic     sum_upd;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic close;
    logic stopped;
    logic gain_step;
    logic sqrt_done;
    logic out_block;
  } dp_status_t;

  localparam int unsigned SQRT_STEPS = 25;
  localparam logic [31:0] HALF_Q20   = 32'h0008_0000;
  localparam logic [25:0] SUM_MAX    = 26'h3FF_FFFF;
  localparam logic [1:0]  GAIN_MAX   = 2'd3;

endpackage

FILE: design/spectral_band_vocoder.sv
// Spectral band vocoder: sums magnitude bins into log-spaced bands and emits
// one scaled square-root value per closed band whose target bin is in range.
// Input channel: in_valid_i / in_stall_o carry one bin item (magnitude and
// last-bin flag). Output channel: out_valid_o / out_stall_i carry a result
// item when a band value is produced or the frame's last bin went by.
// Configuration: cfg_valid_i / cfg_ready_o write register cfg_index_i with
// cfg_data_i; ready is always high. Write only while the block is idle.
// Flow: items are handled one at a time by the controller. Each bin is
// evaluated; one that closes a band runs the 25-step bit-serial square root,
// gain scale, value capture and band update; then come the gain check, a gain
// step if due and the sum update, all skipped once banding has stopped or past
// the spectrum end. The next item can be accepted in the cycle after finish.
// One shared 32x32 multiplier serves the gain scale and both limit ladders.
// The result waits in an output register; while the receiver stalls it, the
// block finishes the next item but holds it until the register frees.
// Reset restores register defaults and the first-frame band state.
module spectral_band_vocoder #(
  parameter int unsigned SPECTRUM_SIZE = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbv_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbv_pkg::out_item_t out_data_o
);
  import sbv_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready_o = 1'b1;

  sbv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  sbv_datapath #(
    .SPECTRUM_SIZE (SPECTRUM_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/sbv_ctrl.sv
module sbv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sbv_pkg::dp_status_t st_i,
  output sbv_pkg::dp_cmd_t    cmd_o
);
  import sbv_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_GAIN;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st_i.close) begin
          cmd_o.sqrt_start = 1'b1;
          state_d = S_SQRT;
        end else if (st_i.active) begin
          state_d = S_GCHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (st_i.sqrt_done) state_d = S_GMUL;
      end
      S_GMUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GAIN;
        state_d = S_VAL;
      end
      S_VAL: begin
        cmd_o.val_capture = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BAND;
        state_d = S_BUPD;
      end
      S_BUPD: begin
        cmd_o.band_upd = 1'b1;
        state_d = S_GCHK;
      end
      S_GCHK: begin
        if (st_i.stopped) begin
          state_d = S_FIN;
        end else if (st_i.gain_step) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MUL_GLIM;
          state_d = S_GUPD;
        end else begin
          state_d = S_SUM;
        end
      end
      S_GUPD: begin
        cmd_o.gain_upd = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_upd = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!st_i.out_block) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> state_q == S_EVAL)
    else $error("accepted item did not enter evaluation");
  a_sqrt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT && !st_i.sqrt_done) |=> state_q == S_SQRT)
    else $error("square root left early");
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == S_IDLE && !in_stall_o))
    else $error("finish did not return to idle");

endmodule

FILE: design/sbv_datapath.sv
module sbv_datapath #(
  parameter int unsigned SPECTRUM_SIZE = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  input  sbv_pkg::in_item_t   in_data_i,
  input  sbv_pkg::dp_cmd_t    cmd_i,
  output sbv_pkg::dp_status_t st_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sbv_pkg::out_item_t  out_data_o
);
  import sbv_pkg::*;

  localparam int unsigned CW = $clog2(SPECTRUM_SIZE + 1);
  localparam int unsigned LW = (CW > 11) ? CW : 11;
  localparam int unsigned TW = LW + 2;
  localparam logic [CW-1:0] SIZE_C = CW'(SPECTRUM_SIZE);

  // configuration
  logic [6:0]  num_bands_q;
  logic [10:0] first_band_q;
  logic [31:0] band_factor_q, gain_factor_q;
  logic [11:0] freq_shift_q, first_osc_q;
  logic [63:0] gains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bands_q   <= 7'd8;
      first_band_q  <= 11'd5;
      band_factor_q <= 32'd2097152;
      gain_factor_q <= 32'd1572864;
      freq_shift_q  <= 12'd0;
      first_osc_q   <= 12'd128;
      gains_q       <= 64'h1000_1000_1000_1000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NUM_BANDS:   num_bands_q   <= cfg_data_i[6:0];
        REG_FIRST_BAND:  first_band_q  <= cfg_data_i[10:0];
        REG_BAND_FACTOR: band_factor_q <= cfg_data_i[31:0];
        REG_GAIN_FACTOR: gain_factor_q <= cfg_data_i[31:0];
        REG_FREQ_SHIFT:  freq_shift_q  <= cfg_data_i[11:0];
        REG_FIRST_OSC:   first_osc_q   <= cfg_data_i[11:0];
        REG_GAINS:       gains_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame state
  logic [25:0]        sum_q;
  logic [31:0]        blim_frac_q, glim_frac_q;
  logic [LW-1:0]      blim_q;
  logic signed [TW-1:0] target_q;
  logic [7:0]         bands_q;
  logic [1:0]         gidx_q;
  logic               stopped_q;
  logic [CW-1:0]      cnt_q;
  logic [15:0]        mag_q;
  logic               last_q;
  logic               has_q;
  logic [9:0]         obin_q;
  logic [15:0]        omag_q;
  logic [63:0]        prod_q;
  logic [26:0]        rem_q;
  logic [24:0]        root_q;
  logic [49:0]        sqv_q;
  logic [4:0]         sqc_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // combinational helpers
  logic [12:0] glim_bin;
  logic [43:0] adv_sum;
  logic [31:0] adv_frac;
  logic [12:0] new_lim13;
  logic [LW-1:0] new_lim;
  logic signed [TW-1:0] new_target;
  logic [28:0] rem_sh, trial;
  logic [40:0] val_sum;
  logic [16:0] val_raw;
  logic [15:0] val_sat;
  logic [15:0] gain_sel;
  logic [31:0] mul_a, mul_b;
  logic [26:0] sum_next;
  logic        emit;

  assign glim_bin = 13'((33'(glim_frac_q) + 33'(HALF_Q20)) >> 20);
  assign adv_sum  = 44'((prod_q + 64'(HALF_Q20)) >> 20);
  assign adv_frac = (|adv_sum[43:32]) ? 32'hFFFF_FFFF : adv_sum[31:0];
  assign new_lim13 = 13'((33'(adv_frac) + 33'(HALF_Q20)) >> 20);
  assign new_lim  = (14'(new_lim13) > 14'(SPECTRUM_SIZE)) ? LW'(SPECTRUM_SIZE)
                                                          : LW'(new_lim13);
  assign new_target = $signed(TW'((({1'b0, new_lim} + {1'b0, blim_q}) >> 1)))
                      + TW'($signed(freq_shift_q));

  assign rem_sh = {rem_q, sqv_q[49:48]};
  assign trial  = {2'b00, root_q, 2'b01};

  assign gain_sel = gains_q[16*gidx_q +: 16];
  assign val_sum  = prod_q[40:0] + 41'h80_0000;
  assign val_raw  = val_sum[40:24];
  assign val_sat  = val_raw[16] ? 16'hFFFF : val_raw[15:0];

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_BAND: begin mul_a = blim_frac_q; mul_b = band_factor_q; end
      MUL_GLIM: begin mul_a = glim_frac_q; mul_b = gain_factor_q; end
      default:  begin mul_a = {7'd0, root_q}; mul_b = {16'd0, gain_sel}; end
    endcase
  end

  assign sum_next = {1'b0, sum_q} + 27'(mag_q);
  assign emit = has_q | last_q;

  assign st_o.active    = (cnt_q < SIZE_C) && !stopped_q;
  assign st_o.close     = st_o.active && (LW'(cnt_q) > blim_q);
  assign st_o.stopped   = stopped_q;
  assign st_o.gain_step = (14'(cnt_q) > 14'(glim_bin));
  assign st_o.sqrt_done = (sqc_q == 5'(SQRT_STEPS - 1));
  assign st_o.out_block = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
    if (cmd_i.accept) begin
      mag_q  <= in_data_i.bin_magnitude;
      last_q <= in_data_i.last_bin;
    end
    if (cmd_i.sqrt_start) begin
      rem_q  <= '0;
      root_q <= '0;
      sqv_q  <= {sum_q, 24'd0};
    end else if (cmd_i.sqrt_step) begin
      sqv_q <= {sqv_q[47:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= 27'(rem_sh - trial);
        root_q <= {root_q[23:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[26:0];
        root_q <= {root_q[23:0], 1'b0};
      end
    end
    if (cmd_i.val_capture) begin
      obin_q <= target_q[9:0];
      omag_q <= val_sat;
    end
    if (cmd_i.finish && emit) begin
      out_q.out_bin       <= has_q ? obin_q : 10'd0;
      out_q.out_magnitude <= has_q ? omag_q : 16'd0;
      out_q.has_value     <= has_q;
      out_q.frame_done    <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      blim_frac_q <= {1'b0, 11'd5, 20'd0};
      blim_q      <= LW'(11'd5);
      target_q    <= TW'(128);
      bands_q     <= '0;
      gidx_q      <= '0;
      glim_frac_q <= {11'd10, 21'd0} >> 1;
      stopped_q   <= 1'b0;
      cnt_q       <= '0;
      has_q       <= 1'b0;
      sqc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        has_q <= 1'b0;
        if (cnt_q == '0) begin
          sum_q       <= '0;
          blim_frac_q <= {1'b0, first_band_q, 20'd0};
          blim_q      <= LW'(first_band_q);
          target_q    <= TW'($signed(first_osc_q));
          bands_q     <= '0;
          gidx_q      <= '0;
          glim_frac_q <= {first_band_q, 21'd0};
          stopped_q   <= 1'b0;
        end
      end
      if (cmd_i.sqrt_start) sqc_q <= '0;
      else if (cmd_i.sqrt_step) sqc_q <= sqc_q + 5'd1;
      if (cmd_i.val_capture) begin
        has_q <= (target_q >= 0) && (target_q < $signed(TW'(SPECTRUM_SIZE)));
      end
      if (cmd_i.band_upd) begin
        blim_frac_q <= adv_frac;
        blim_q      <= new_lim;
        target_q    <= new_target;
        sum_q       <= '0;
        bands_q     <= bands_q + 8'd1;
        if ((bands_q + 8'd1) > {1'b0, num_bands_q}) stopped_q <= 1'b1;
      end
      if (cmd_i.gain_upd) begin
        if (gidx_q < GAIN_MAX) gidx_q <= gidx_q + 2'd1;
        glim_frac_q <= adv_frac;
      end
      if (cmd_i.sum_upd) begin
        sum_q <= sum_next[26] ? SUM_MAX : sum_next[25:0];
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.finish) begin
        if (emit) out_valid_q <= 1'b1;
        if (last_q) cnt_q <= '0;
        else if (cnt_q < SIZE_C) cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sbv_pkg::*;

  localparam int unsigned SPEC = 1024;
  localparam int unsigned SETTLE = 60;
  localparam int unsigned WATCHDOG_MAX = 5000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  spectral_band_vocoder #(.SPECTRUM_SIZE(SPEC)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // register copies
  logic [6:0]  r_num_bands;
  logic [10:0] r_first_band;
  logic [31:0] r_band_factor;
  logic [31:0] r_gain_factor;
  logic [11:0] r_freq_shift;
  logic [11:0] r_first_osc;
  logic [63:0] r_gains;

  // band state
  longint unsigned band_acc;
  logic [31:0] lim_frac;
  int unsigned lim_bin;
  int unsigned prev_lim;
  int          osc_target;
  int unsigned closes;
  int unsigned gain_sel;
  logic [31:0] gain_frac;
  int unsigned bin_idx;
  bit          halted;

  out_item_t   band_values_q[$];
  int unsigned mismatches = 0;
  bit          hold_req = 1'b0;
  int unsigned burst_left = 0;

  function automatic int sx12(logic [11:0] v);
    return int'(signed'(v));
  endfunction

  function automatic int unsigned q20_round(logic [31:0] f);
    return int'((longint'(f) + 64'h80000) >> 20);
  endfunction

  function automatic logic [31:0] q20_scale(logic [31:0] f, logic [31:0] k);
    longint unsigned p;
    p = (longint'(f) * longint'(k) + 64'h80000) >> 20;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void restart_frame();
    band_acc = 0;
    lim_frac = {r_first_band, 20'd0};
    lim_bin = r_first_band;
    prev_lim = 0;
    osc_target = sx12(r_first_osc);
    closes = 0;
    gain_sel = 0;
    gain_frac = 32'({r_first_band, 1'b0}) << 20;
    halted = 1'b0;
  endfunction

  // advances the band state by one bin, returns 1 when a result item is due
  function automatic bit band_step(input in_item_t it, output out_item_t res);
    int unsigned i;
    longint unsigned root, g, v;
    int unsigned nl;
    i = bin_idx;
    res = '0;
    if (i == 0) restart_frame();
    if (i < SPEC && !halted) begin
      if (i > lim_bin) begin
        root = int_sqrt(band_acc << 24);
        g = (r_gains >> (16 * gain_sel)) & 64'hFFFF;
        v = (root * g + (64'h1 << 23)) >> 24;
        if (v > 64'hFFFF) v = 64'hFFFF;
        if (osc_target >= 0 && osc_target < SPEC) begin
          res.has_value = 1'b1;
          res.out_bin = osc_target[9:0];
          res.out_magnitude = v[15:0];
        end
        prev_lim = lim_bin;
        lim_frac = q20_scale(lim_frac, r_band_factor);
        nl = q20_round(lim_frac);
        lim_bin = (nl > SPEC) ? SPEC : nl;
        osc_target = int'((lim_bin + prev_lim) >> 1) + sx12(r_freq_shift);
        band_acc = 0;
        closes++;
        if (closes > r_num_bands) halted = 1'b1;
      end
      if (!halted) begin
        if (i > q20_round(gain_frac)) begin
          if (gain_sel < 3) gain_sel++;
          gain_frac = q20_scale(gain_frac, r_gain_factor);
        end
        band_acc += it.bin_magnitude;
        if (band_acc > 64'h3FF_FFFF) band_acc = 64'h3FF_FFFF;
      end
    end
    if (it.last_bin) bin_idx = 0;
    else if (i < SPEC) bin_idx = i + 1;
    res.frame_done = it.last_bin;
    return res.has_value || it.last_bin;
  endfunction

  task automatic send_bin(input logic [15:0] mag, input logic last, input bit typed,
                          input out_item_t typed_exp);
    out_item_t r;
    bit due;
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i <= '{bin_magnitude: mag, last_bin: last};
    do @(posedge clk_i); while (in_stall_o);
    due = band_step('{bin_magnitude: mag, last_bin: last}, r);
    if (typed) band_values_q.push_back(typed_exp);
    else if (due) band_values_q.push_back(r);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (band_values_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(input reg_index_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_NUM_BANDS:   r_num_bands = val[6:0];
      REG_FIRST_BAND:  r_first_band = val[10:0];
      REG_BAND_FACTOR: r_band_factor = val[31:0];
      REG_GAIN_FACTOR: r_gain_factor = val[31:0];
      REG_FREQ_SHIFT:  r_freq_shift = val[11:0];
      REG_FIRST_OSC:   r_first_osc = val[11:0];
      REG_GAINS:       r_gains = val;
      default: ;
    endcase
  endtask

  // kind 0: low extremes, 1: high extremes, else random in useful ranges
  task automatic program_regs(input int kind);
    logic [63:0] v[7];
    if (kind == 0) begin
      v = '{64'd0, 64'd0, 64'd0, 64'd0, 64'hFFF, 64'd0, 64'd0};
    end else if (kind == 1) begin
      v = '{64'h7F, 64'h7FF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'h7FF, 64'h7FF, '1};
    end else begin
      v[0] = $urandom_range(0, 20);
      v[1] = $urandom_range(0, 12);
      v[2] = $urandom_range(32'h0010_0000, 32'h0030_0000);
      v[3] = $urandom_range(32'h0010_0000, 32'h0040_0000);
      v[4] = $urandom_range(0, 40) - 20;
      v[5] = $urandom_range(0, 1100) - 50;
      v[6] = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) v[2] = $urandom;
      if ($urandom_range(0, 3) == 0) v[4] = $urandom;
    end
    for (int k = 0; k < 7; k++) write_reg(reg_index_e'(k), v[k]);
  endtask

  function automatic logic [15:0] rand_mag();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  typedef struct {
    logic [15:0] mag;
    logic        last;
    bit          typed;
    out_item_t   exp;
  } bin_row_t;

  localparam out_item_t FRAME_END = '{out_bin: '0, out_magnitude: '0, has_value: 1'b0,
                                      frame_done: 1'b1};

  bin_row_t directed[] = '{
    '{16'd100, 1'b1, 1'b1, FRAME_END},
    '{16'h0000, 1'b0, 1'b0, '0}, '{16'hFFFF, 1'b0, 1'b0, '0},
    '{16'hFFFF, 1'b0, 1'b0, '0}, '{16'h0001, 1'b0, 1'b0, '0},
    '{16'h5555, 1'b0, 1'b0, '0}, '{16'hAAAA, 1'b0, 1'b0, '0},
    '{16'hFFFF, 1'b0, 1'b0, '0}, '{16'hFFFF, 1'b0, 1'b0, '0},
    '{16'h8000, 1'b0, 1'b0, '0}, '{16'h7FFF, 1'b0, 1'b0, '0},
    '{16'hFFFF, 1'b0, 1'b0, '0}, '{16'h0000, 1'b0, 1'b0, '0},
    '{16'hFFFF, 1'b0, 1'b0, '0}, '{16'h1234, 1'b1, 1'b0, '0},
    '{16'hFFFF, 1'b1, 1'b1, FRAME_END},
    '{16'h0000, 1'b1, 1'b1, FRAME_END}
  };

  // receiver: checks each result item, stalls in a randomly redrawn pattern, plus one long hold-off
  initial begin
    int unsigned mode, hold_left;
    int unsigned cyc;
    bit s;
    mode = 0;
    hold_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (band_values_q.size() == 0) begin
          $error("result item with nothing expected: %p", out_data_o);
          mismatches++;
        end else begin
          out_item_t e;
          e = band_values_q.pop_front();
          if (e.out_bin !== out_data_o.out_bin) begin
            $error("out_bin expected %0d actual %0d", e.out_bin, out_data_o.out_bin);
            mismatches++;
          end
          if (e.out_magnitude !== out_data_o.out_magnitude) begin
            $error("out_magnitude expected %0d actual %0d", e.out_magnitude,
                   out_data_o.out_magnitude);
            mismatches++;
          end
          if (e.has_value !== out_data_o.has_value) begin
            $error("has_value expected %0d actual %0d", e.has_value, out_data_o.has_value);
            mismatches++;
          end
          if (e.frame_done !== out_data_o.frame_done) begin
            $error("frame_done expected %0d actual %0d", e.frame_done,
                   out_data_o.frame_done);
            mismatches++;
          end
        end
      end
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else begin
        case (mode)
          0: s = 1'b0;
          1: s = ($urandom_range(0, 3) == 0);
          2: s = ($urandom_range(0, 3) != 0);
          default: s = cyc[0];
        endcase
      end
      out_stall_i <= s;
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n, flen, pos;
    r_num_bands = 7'd8;
    r_first_band = 11'd5;
    r_band_factor = 32'd2097152;
    r_gain_factor = 32'd1572864;
    r_freq_shift = '0;
    r_first_osc = 12'd128;
    r_gains = 64'h1000_1000_1000_1000;
    bin_idx = 0;
    restart_frame();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send_bin(directed[k].mag, directed[k].last, directed[k].typed,
                                   directed[k].exp);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      program_regs(ph);
      if (ph == 5) begin
        // wide first band with few bands
        write_reg(REG_FIRST_BAND, 64'd40);
        write_reg(REG_NUM_BANDS, 64'd3);
      end
      cfg_valid_i <= 1'b0;
      if (ph == 3) begin
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      if (ph == 5) begin
        for (int b = 0; b < 60; b++) send_bin(16'hFFFF, b == 59, 1'b0, '0);
      end
      n = 0;
      while (n < 70) begin
        flen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(10, 90);
        for (pos = 0; pos < flen && n < 70; pos++) begin
          send_bin(rand_mag(), pos == flen - 1, 1'b0, '0);
          n++;
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
